/* hw/rtl/mis_pkg.sv */
// ----------------------------------------------------------------------------
// mis_pkg: shared types and constants of the merge-insertion sorter
// Value width, default capacity and the per-cycle command that is sent to
// every cell of the insertion chain.
// ----------------------------------------------------------------------------
package mis_pkg;

	localparam int VALUE_W      = 31;
	localparam int CAPACITY_DEF = 64;

	typedef logic [VALUE_W-1:0] value_t;

	// Command broadcast to the chain in one cycle.
	typedef struct packed {
		logic   insert;   // place value into the ordered row
		logic   shift;    // move every entry one cell toward the head
		value_t value;    // value being inserted
	} cell_ctl_t;

endpackage

/* hw/rtl/mis_if.sv */
// ----------------------------------------------------------------------------
// mis_if: valid/ready channels of the merge-insertion sorter
// One interface for the value stream in and one for the sorted stream out.
// ----------------------------------------------------------------------------
interface mis_in_if;
	logic                       valid;
	logic                       ready;
	logic [mis_pkg::VALUE_W-1:0] value;
	logic                       is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface mis_out_if;
	logic                       valid;
	logic                       ready;
	logic [mis_pkg::VALUE_W-1:0] sorted_value;
	logic                       is_last_res;
	logic                       overflow;

	modport source (output valid, output sorted_value, output is_last_res,
		output overflow, input ready);
	modport sink   (input valid, input sorted_value, input is_last_res,
		input overflow, output ready);
endinterface

/* hw/rtl/mis_cell.sv */
// ----------------------------------------------------------------------------
// mis_cell: one cell of the insertion chain
// Holds one value and its occupied bit. On insert it keeps its value, takes
// the new value, or takes its left neighbor's value; on shift it takes its
// right neighbor's entry.
// ----------------------------------------------------------------------------
module mis_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mis_pkg::cell_ctl_t          ctl,
	input  logic                        prev_occ,
	input  logic                        prev_gt,
	input  logic [mis_pkg::VALUE_W-1:0] prev_val,
	input  logic                        next_occ,
	input  logic [mis_pkg::VALUE_W-1:0] next_val,
	output logic                        occ,
	output logic                        gt,
	output logic [mis_pkg::VALUE_W-1:0] val
);
	import mis_pkg::*;

	logic   occ_q;
	value_t val_q;
	logic   take;

	assign gt   = occ_q && (val_q > ctl.value);
	// take a new entry when ours moves right or when this is the first free cell
	assign take = gt || (!occ_q && prev_occ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.shift) begin
			occ_q <= next_occ;
		end else if (ctl.insert) begin
			occ_q <= occ_q | prev_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= next_val;
		end else if (ctl.insert && take) begin
			val_q <= prev_gt ? prev_val : ctl.value;
		end
	end

	assign occ = occ_q;
	assign val = val_q;

endmodule

/* hw/rtl/merge_insertion_sorter.sv */
// ----------------------------------------------------------------------------
// merge_insertion_sorter: streaming sorter built on a systolic insertion chain
// Loads a set of values, then emits them in ascending order.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                              | transfer
//  items    | in  | value[30:0], is_last                 | valid && ready
//  results  | out | sorted_value[30:0], is_last_res, ovf | valid && ready
//
//  Loading takes one value per cycle: every cell compares against the new
//  value in parallel and the row opens a gap in one step.
//  After the marked item, the set drains one value per cycle from the head
//  cell while results is ready; items is not ready until the last result
//  is taken, whose transfer clears the drain state.
//  A stalled results channel holds the head cell; nothing moves.
//  Reset empties the chain and clears the overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module merge_insertion_sorter #(
	parameter int CAPACITY = mis_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mis_in_if.sink    items,
	mis_out_if.source results
);
	import mis_pkg::*;

	logic              drain_q;
	logic              ovf_q;
	cell_ctl_t         ctl;
	logic              in_xfer;
	logic              out_xfer;
	logic              full;
	logic [CAPACITY-1:0] occ_vec;
	logic [CAPACITY-1:0] gt_vec;
	value_t            val_arr [CAPACITY];

	assign items.ready = !drain_q;
	assign in_xfer     = items.valid && items.ready;
	assign out_xfer    = results.valid && results.ready;
	assign full        = occ_vec[CAPACITY-1];

	assign ctl.insert = in_xfer && !full;
	assign ctl.shift  = out_xfer;
	assign ctl.value  = items.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   p_occ;
		logic   p_gt;
		value_t p_val;
		logic   n_occ;
		value_t n_val;

		if (i == 0) begin : g_head
			assign p_occ = 1'b1;
			assign p_gt  = 1'b0;
			assign p_val = '0;
		end else begin : g_body
			assign p_occ = occ_vec[i-1];
			assign p_gt  = gt_vec[i-1];
			assign p_val = val_arr[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign n_occ = 1'b0;
			assign n_val = '0;
		end else begin : g_link
			assign n_occ = occ_vec[i+1];
			assign n_val = val_arr[i+1];
		end

		mis_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev_occ (p_occ),
			.prev_gt  (p_gt),
			.prev_val (p_val),
			.next_occ (n_occ),
			.next_val (n_val),
			.occ      (occ_vec[i]),
			.gt       (gt_vec[i]),
			.val      (val_arr[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (out_xfer && results.is_last_res) begin
			// set done: reopen for the next one
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (in_xfer) begin
			drain_q <= items.is_last;
			ovf_q   <= ovf_q | full;
		end
	end

	assign results.valid        = drain_q && occ_vec[0];
	assign results.sorted_value = val_arr[0];
	assign results.is_last_res  = !occ_vec[1];
	assign results.overflow     = ovf_q;

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(items.ready && results.valid))
		else $error("input accepted while results pending");

	a_occ_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, occ_vec} + {{CAPACITY{1'b0}}, 1'b1}))
		else $error("occupied cells do not form a prefix");

	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && results.is_last_res |=> items.ready && !occ_vec[0] && !ovf_q)
		else $error("chain not empty after last result");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> $past(full))
		else $error("overflow raised with room left");
`endif

endmodule
